// ===== rtl/core/af128_pkg.sv =====
// Shared types and constants for the 128-bit array fingerprint block.
package af128_pkg;

  // Item operation codes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Mixing scheme codes; the fourth code behaves as hash combine.
  localparam logic [1:0] MODE_HASH   = 2'd0;
  localparam logic [1:0] MODE_CANTOR = 2'd1;
  localparam logic [1:0] MODE_TUPLE  = 2'd2;
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_SEED = 2'd1;
  localparam logic [1:0] REG_TAG  = 2'd2;

  // Mixer constants.
  localparam logic [63:0] GOLD = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MULA = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MULB = 64'h94D049BB133111EB;

  localparam logic [63:0] HC_LOW   = 64'h6A09E667F3BCC909;
  localparam logic [63:0] HC_HIGH  = 64'hBB67AE8584CAA73B;
  localparam logic [63:0] HC_INDEX = 64'h3C6EF372FE94F82B;
  localparam logic [63:0] HC_LEN   = 64'hD6E8FEB86659FD93;

  localparam logic [63:0] CM_LOW  = 64'h510E527FADE682D1;
  localparam logic [63:0] CM_HIGH = 64'h9B05688C2B3E6C1F;
  localparam logic [63:0] CM_PAIR = 64'h1F83D9ABFB41BD6B;

  localparam logic [63:0] TM_LOW  = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] TM_HIGH = 64'h165667B19E3779F9;
  localparam logic [63:0] TM_PAIR = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] TM_FILL = 64'h27D4EB2F165667C5;
  localparam logic [63:0] TM_LEN  = 64'h9E3779B185EBCA87;

  // One queued input word.
  typedef struct packed {
    logic        op;
    logic [63:0] word;
  } item_t;

  // Live configuration.
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] seed;
    logic [63:0] tag;
  } cfg_t;

  // Request to the shared mixing unit.
  typedef struct packed {
    logic        start;
    logic        is_mul;
    logic [63:0] a;
    logic [63:0] b;
  } mix_req_t;

  // Left rotation of a 64-bit value.
  function automatic logic [63:0] rotl(input logic [63:0] v, input int unsigned k);
    rotl = (v << k) | (v >> (64 - k));
  endfunction

endpackage

// ===== rtl/core/af128_front.sv =====
// Front end: two-entry queue that takes input words and hands them to the back end.
module af128_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [63:0]       in_word,
  output logic              q_valid,
  output af128_pkg::item_t  q_item,
  input  logic              q_pop
);

  af128_pkg::item_t mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].op   <= in_op;
      mem_r[wp_r].word <= in_word;
    end
  end

endmodule

// ===== rtl/core/af128_mix.sv =====
// Shared mixing unit: splitmix64 finalizer or a 64-bit low-half multiply on one 32x32 multiplier.
module af128_mix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  af128_pkg::mix_req_t  req,
  output logic                 done,
  output logic [63:0]          res
);

  typedef enum logic [1:0] {MX_IDLE, MX_P0, MX_P1, MX_P2} mx_state_t;

  mx_state_t   state_r;
  logic [63:0] x_r, k_r, acc_r, res_r;
  logic        sm_r, second_r, done_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] ld;
  logic [63:0] fin;

  assign done = done_r;
  assign res  = res_r;

  // Operand selection for the one multiplier by phase.
  always_comb begin
    case (state_r)
      MX_P1:   begin mul_a = x_r[31:0];  mul_b = k_r[63:32]; end
      MX_P2:   begin mul_a = x_r[63:32]; mul_b = k_r[31:0];  end
      default: begin mul_a = x_r[31:0];  mul_b = k_r[31:0];  end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign ld   = req.a + af128_pkg::GOLD;
  assign fin  = acc_r + {prod[31:0], 32'd0};

  // Phase sequencer: three partial products per multiply, two multiplies per splitmix round, one per plain multiply.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MX_IDLE: begin
          if (req.start) begin
            second_r <= 1'b0;
            sm_r     <= ~req.is_mul;
            if (req.is_mul) begin
              x_r <= req.a;
              k_r <= req.b;
            end else begin
              x_r <= ld ^ (ld >> 30);
              k_r <= af128_pkg::MULA;
            end
            state_r <= MX_P0;
          end
        end
        MX_P0: begin
          acc_r   <= prod;
          state_r <= MX_P1;
        end
        MX_P1: begin
          acc_r   <= fin;
          state_r <= MX_P2;
        end
        MX_P2: begin
          if (sm_r && !second_r) begin
            x_r      <= fin ^ (fin >> 27);
            k_r      <= af128_pkg::MULB;
            second_r <= 1'b1;
            state_r  <= MX_P0;
          end else begin
            res_r   <= sm_r ? (fin ^ (fin >> 31)) : fin;
            done_r  <= 1'b1;
            state_r <= MX_IDLE;
          end
        end
        default: state_r <= MX_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/af128_back.sv =====
// Back end: per-array state and the sequencer that runs each word through the mixing unit.
module af128_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  af128_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  af128_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_fp_low,
  output logic [63:0]       out_fp_high,
  output logic [31:0]       out_word_count
);

  typedef enum logic [2:0] {ST_IDLE, ST_START, ST_ISSUE, ST_WAIT, ST_DONE} st_t;

  typedef enum logic [5:0] {
    PC_NONE, PC_S1, PC_S2, PC_S3,
    PC_A1, PC_A2, PC_A3, PC_A4, PC_A5,
    PC_B1, PC_B2, PC_B3, PC_B4, PC_B5, PC_B6,
    PC_P1, PC_P2, PC_P3, PC_P4, PC_P5, PC_P6,
    PC_E1, PC_E2, PC_E3, PC_E4,
    PC_F1,
    PC_G1, PC_G2, PC_G3, PC_G4, PC_G5
  } pc_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  st_t                    state_r;
  pc_t                    pc_r, body_pc, next_pc;
  logic [1:0]             mode_r, mode_n;
  logic                   op_r;
  logic [63:0]            word_r, rhs_r, pl_r, ph_r;
  logic [63:0]            acc_lo_r, acc_hi_r, u_r, ix_r, t_r, held_r;
  logic                   held_v_r, started_r;
  logic [COUNT_WIDTH-1:0] pos_r;
  logic                   out_valid_r;
  logic                   out_load;
  logic [63:0]            out_lo_r, out_hi_r;
  logic [31:0]            out_cnt_r;
  af128_pkg::mix_req_t    req;
  logic                   mix_done;
  logic [63:0]            mix_res;
  logic [63:0]            pos64, pidx, seed_lo, seed_hi;
  logic [16:0]            s_lo, s_hi;
  logic [33:0]            c_lo, c_hi;

  assign out_valid      = out_valid_r;
  assign out_fp_low     = out_lo_r;
  assign out_fp_high    = out_hi_r;
  assign out_word_count = out_cnt_r;
  assign q_pop          = (state_r == ST_IDLE) && q_valid;

  // A finished end word loads the result register once it is free.
  assign out_load = (state_r == ST_DONE) && (op_r == af128_pkg::OP_END)
                    && (!out_valid_r || out_ready);

  assign mode_n = (cfg.mode == af128_pkg::MODE_SPARE) ? af128_pkg::MODE_HASH : cfg.mode;
  assign pos64  = 64'(pos_r);
  assign pidx   = 64'(COUNT_WIDTH'(pos_r - 1'b1) >> 1);

  // Cantor pairing of the word's 16-bit quarters.
  assign s_lo = 17'(q_item.word[15:0]) + 17'(q_item.word[31:16]);
  assign s_hi = 17'(q_item.word[47:32]) + 17'(q_item.word[63:48]);
  assign c_lo = 34'(s_lo) * 34'(s_lo + 17'd1);
  assign c_hi = 34'(s_hi) * 34'(s_hi + 17'd1);

  // Seed constants for the scheme in force.
  always_comb begin
    case (mode_r)
      af128_pkg::MODE_CANTOR: begin
        seed_lo = af128_pkg::CM_LOW; seed_hi = af128_pkg::CM_HIGH;
      end
      af128_pkg::MODE_TUPLE: begin
        seed_lo = af128_pkg::TM_LOW; seed_hi = af128_pkg::TM_HIGH;
      end
      default: begin
        seed_lo = af128_pkg::HC_LOW; seed_hi = af128_pkg::HC_HIGH;
      end
    endcase
  end

  // First step of the item's own work, after any seeding.
  always_comb begin
    if (op_r == af128_pkg::OP_DATA) begin
      case (mode_r)
        af128_pkg::MODE_CANTOR: body_pc = PC_B1;
        af128_pkg::MODE_TUPLE:  body_pc = held_v_r ? PC_P1 : PC_NONE;
        default:                body_pc = PC_A1;
      endcase
    end else begin
      body_pc = (mode_r == af128_pkg::MODE_TUPLE) ? (held_v_r ? PC_F1 : PC_G1) : PC_E1;
    end
  end

  // Step sequence.
  always_comb begin
    case (pc_r)
      PC_S3:   next_pc = body_pc;
      PC_A5, PC_B6, PC_E4, PC_G5: next_pc = PC_NONE;
      PC_P6:   next_pc = (op_r == af128_pkg::OP_END) ? PC_G1 : PC_NONE;
      PC_F1:   next_pc = PC_P1;
      PC_NONE: next_pc = PC_NONE;
      default: next_pc = pc_t'(pc_r + 6'd1);
    endcase
  end

  // Operand of the current step.
  always_comb begin
    req.start  = (state_r == ST_ISSUE);
    req.is_mul = 1'b0;
    req.b      = '0;
    case (pc_r)
      PC_S1: req.a = cfg.seed ^ seed_lo ^ cfg.tag;
      PC_S2: req.a = cfg.tag;
      PC_S3: req.a = cfg.seed ^ seed_hi ^ u_r;
      PC_A1: req.a = pos64 ^ af128_pkg::HC_INDEX;
      PC_A2: req.a = word_r ^ u_r;
      PC_A3: req.a = acc_lo_r ^ ix_r ^ (pos64 << 1);
      PC_A4: req.a = pos64 ^ cfg.seed;
      PC_A5: req.a = acc_hi_r + ix_r + u_r;
      PC_B1: req.a = pos64 ^ cfg.seed ^ af128_pkg::CM_PAIR;
      PC_B2: req.a = ph_r;
      PC_B3: req.a = pl_r ^ u_r ^ ix_r;
      PC_B4: req.a = acc_lo_r ^ t_r ^ pos64;
      PC_B5: req.a = cfg.tag ^ ix_r;
      PC_B6: req.a = acc_hi_r + t_r + u_r;
      PC_P1: req.a = pidx ^ cfg.seed ^ af128_pkg::TM_PAIR;
      PC_P2: req.a = cfg.tag;
      PC_P3: req.a = held_r ^ af128_pkg::rotl(rhs_r, 17) ^ ix_r ^ u_r;
      PC_P4: req.a = acc_lo_r + t_r + af128_pkg::rotl(t_r, 23);
      PC_P5: req.a = pidx;
      PC_P6: req.a = acc_hi_r ^ t_r ^ af128_pkg::rotl(t_r, 41) ^ u_r;
      PC_E1: req.a = cfg.tag;
      PC_E2: req.a = acc_lo_r ^ pos64 ^ cfg.tag;
      PC_E3: begin
        req.a      = pos64;
        req.is_mul = 1'b1;
        req.b      = (mode_r == af128_pkg::MODE_CANTOR) ? af128_pkg::MULB : af128_pkg::HC_LEN;
      end
      PC_E4: req.a = acc_hi_r ^ t_r ^ u_r;
      PC_F1: req.a = pos64 ^ cfg.seed ^ cfg.tag ^ af128_pkg::TM_FILL;
      PC_G1: req.a = cfg.tag ^ af128_pkg::TM_LOW;
      PC_G2: req.a = acc_lo_r ^ pos64 ^ u_r;
      PC_G3: begin
        req.a      = pos64;
        req.is_mul = 1'b1;
        req.b      = af128_pkg::TM_LEN;
      end
      PC_G4: req.a = cfg.tag ^ af128_pkg::TM_HIGH;
      PC_G5: req.a = acc_hi_r ^ t_r ^ u_r;
      default: req.a = '0;
    endcase
  end

  af128_mix u_mix (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .done (mix_done),
    .res  (mix_res)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Sequencer, per-array state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= PC_NONE;
      acc_lo_r    <= '0;
      acc_hi_r    <= '0;
      pos_r       <= '0;
      held_r      <= '0;
      held_v_r    <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            op_r    <= q_item.op;
            word_r  <= q_item.word;
            rhs_r   <= q_item.word;
            mode_r  <= mode_n;
            pl_r    <= 64'(c_lo[33:1]) + 64'(q_item.word[31:16]);
            ph_r    <= 64'(c_hi[33:1]) + 64'(q_item.word[63:48]);
            state_r <= ST_START;
          end
        end
        ST_START: begin
          // Seed first if needed, otherwise go straight to the item's own steps.
          if (!started_r) begin
            pc_r    <= PC_S1;
            state_r <= ST_ISSUE;
          end else begin
            pc_r    <= body_pc;
            state_r <= (body_pc == PC_NONE) ? ST_DONE : ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mix_done) begin
            case (pc_r)
              PC_S1, PC_A3, PC_B4, PC_P4, PC_E2, PC_G2: acc_lo_r <= mix_res;
              PC_S3, PC_A5, PC_B6, PC_P6, PC_E4, PC_G5: acc_hi_r <= mix_res;
              PC_A2, PC_B1, PC_P1:                      ix_r     <= mix_res;
              PC_B3, PC_P3, PC_E3, PC_G3:               t_r      <= mix_res;
              PC_F1:                                    rhs_r    <= mix_res;
              default:                                  u_r      <= mix_res;
            endcase
            if (pc_r == PC_S3) started_r <= 1'b1;
            pc_r    <= next_pc;
            state_r <= (next_pc == PC_NONE) ? ST_DONE : ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (op_r == af128_pkg::OP_DATA) begin
            if (pos_r != CNT_MAX) pos_r <= pos_r + 1'b1;
            if (mode_r == af128_pkg::MODE_TUPLE) begin
              held_v_r <= ~held_v_r;
              held_r   <= held_v_r ? 64'd0 : word_r;
            end
            state_r <= ST_IDLE;
          end else if (out_load) begin
            out_lo_r    <= acc_lo_r;
            out_hi_r    <= acc_hi_r;
            out_cnt_r   <= 32'(pos_r);
            acc_lo_r    <= '0;
            acc_hi_r    <= '0;
            pos_r       <= '0;
            held_r      <= '0;
            held_v_r    <= 1'b0;
            started_r   <= 1'b0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/array_fingerprint_128.sv =====
// Top level of the streaming 128-bit array fingerprint block.
// A two-word queue takes input words while the back end works. Each item runs as a
// sequence of splitmix64 rounds and length multiplies on one shared unit built around a
// single 32x32 multiplier. A tuple word is mixed only as the second word of a pair, and
// the first item of an array adds 3 seeding rounds. Finished results sit in an output
// register, so input is taken while a fingerprint waits to be read.
module array_fingerprint_128 #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [63:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_fp_low,
  output logic [63:0] out_fp_high,
  output logic [31:0] out_word_count
);

  af128_pkg::cfg_t  cfg_r;
  logic             q_valid;
  logic             q_pop;
  af128_pkg::item_t q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        af128_pkg::REG_MODE: cfg_r.mode <= cfg_wdata[1:0];
        af128_pkg::REG_SEED: cfg_r.seed <= cfg_wdata;
        af128_pkg::REG_TAG:  cfg_r.tag  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  af128_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op   (in_op),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  af128_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fp_low    (out_fp_low),
    .out_fp_high   (out_fp_high),
    .out_word_count(out_word_count)
  );

endmodule

// ===== rtl/core/af128_checker.sv =====
// Port-level checker for the array fingerprint block and its bind.
module af128_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_fp_low,
  input logic [63:0] out_fp_high,
  input logic [31:0] out_word_count
);

  logic [3:0] pend_r;
  logic       end_in, res_out;

  assign end_in  = in_valid && in_ready && (in_op == af128_pkg::OP_END);
  assign res_out = out_valid && out_ready;

  // End words accepted whose fingerprint is not yet taken.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_r + 4'(end_in) - 4'(res_out);
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fp_low) && $stable(out_fp_high)
      && $stable(out_word_count))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without a pending end word");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind array_fingerprint_128 af128_checker u_af128_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_fp_low    (out_fp_low),
  .out_fp_high   (out_fp_high),
  .out_word_count(out_word_count)
);

// ===== tb/array_fingerprint_128_test.sv =====
// Self-checking testbench for the streaming 128-bit array fingerprint block.
module array_fingerprint_128_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One fingerprint as it leaves the block.
  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] cnt;
  } fp_t;

  // One directed word; the count is typed in where it is obvious.
  typedef struct {
    logic        op;
    logic [63:0] word;
    bit          cnt_known;
    logic [31:0] cnt;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = af128_pkg::REG_MODE;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = af128_pkg::OP_DATA;
  logic [63:0] in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_fp_low;
  logic [63:0] out_fp_high;
  logic [31:0] out_word_count;

  array_fingerprint_128 uut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the configuration and of the per-array state.
  logic [1:0]  sh_mode;
  logic [63:0] sh_seed, sh_tag;
  logic [63:0] acc_lo, acc_hi, pos, held;
  bit          held_ok, seeded;

  fp_t fp_due[$];
  int  n_err = 0, n_items = 0, n_fp = 0, n_ends = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  // One splitmix64 round.
  function automatic logic [63:0] smix(logic [63:0] v);
    logic [63:0] x;
    x = v + af128_pkg::GOLD;
    x = (x ^ (x >> 30)) * af128_pkg::MULA;
    x = (x ^ (x >> 27)) * af128_pkg::MULB;
    return x ^ (x >> 31);
  endfunction

  function automatic logic [63:0] spin(logic [63:0] v, int k);
    return (v << k) | (v >> (64 - k));
  endfunction

  function automatic logic [63:0] pair16(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return ((s * (s + 64'd1)) >> 1) + b;
  endfunction

  // Folds one word pair of tuple mode into the accumulators.
  function automatic void fold_pair(logic [63:0] l, logic [63:0] r, logic [63:0] pidx);
    logic [63:0] tg, t;
    tg = smix(pidx ^ sh_seed ^ af128_pkg::TM_PAIR);
    t = smix(l ^ spin(r, 17) ^ tg ^ smix(sh_tag));
    acc_lo = smix(acc_lo + t + spin(t, 23));
    acc_hi = smix(acc_hi ^ t ^ spin(t, 41) ^ smix(pidx));
  endfunction

  // Advances the shadow state by one accepted word; end words queue a fingerprint.
  function automatic void track_word(logic op, logic [63:0] w);
    logic [1:0]  m;
    logic [63:0] ix, c, fill;
    fp_t         f;
    m = (sh_mode == af128_pkg::MODE_SPARE) ? af128_pkg::MODE_HASH : sh_mode;
    if (!seeded) begin
      if (m == af128_pkg::MODE_CANTOR) begin
        acc_lo = smix(sh_seed ^ af128_pkg::CM_LOW ^ sh_tag);
        acc_hi = smix(sh_seed ^ af128_pkg::CM_HIGH ^ smix(sh_tag));
      end else if (m == af128_pkg::MODE_TUPLE) begin
        acc_lo = smix(sh_seed ^ af128_pkg::TM_LOW ^ sh_tag);
        acc_hi = smix(sh_seed ^ af128_pkg::TM_HIGH ^ smix(sh_tag));
      end else begin
        acc_lo = smix(sh_seed ^ af128_pkg::HC_LOW ^ sh_tag);
        acc_hi = smix(sh_seed ^ af128_pkg::HC_HIGH ^ smix(sh_tag));
      end
      seeded = 1'b1;
    end
    if (op == af128_pkg::OP_DATA) begin
      if (m == af128_pkg::MODE_HASH) begin
        ix = smix(w ^ smix(pos ^ af128_pkg::HC_INDEX));
        acc_lo = smix(acc_lo ^ ix ^ (pos << 1));
        acc_hi = smix(acc_hi + ix + smix(pos ^ sh_seed));
      end else if (m == af128_pkg::MODE_CANTOR) begin
        ix = smix(pos ^ sh_seed ^ af128_pkg::CM_PAIR);
        c = smix(pair16(64'(w[15:0]), 64'(w[31:16]))
                 ^ smix(pair16(64'(w[47:32]), 64'(w[63:48]))) ^ ix);
        acc_lo = smix(acc_lo ^ c ^ pos);
        acc_hi = smix(acc_hi + c + smix(sh_tag ^ ix));
      end else if (held_ok) begin
        fold_pair(held, w, (pos - 64'd1) >> 1);
        held_ok = 1'b0;
        held = '0;
      end else begin
        held = w;
        held_ok = 1'b1;
      end
      if (pos < 64'hFFFF_FFFF) pos++;
      return;
    end
    if (m == af128_pkg::MODE_TUPLE) begin
      if (held_ok) begin
        fill = smix(pos ^ sh_seed ^ sh_tag ^ af128_pkg::TM_FILL);
        fold_pair(held, fill, (pos - 64'd1) >> 1);
      end
      acc_lo = smix(acc_lo ^ pos ^ smix(sh_tag ^ af128_pkg::TM_LOW));
      acc_hi = smix(acc_hi ^ (pos * af128_pkg::TM_LEN)
                    ^ smix(sh_tag ^ af128_pkg::TM_HIGH));
    end else begin
      acc_lo = smix(acc_lo ^ pos ^ sh_tag);
      acc_hi = smix(acc_hi ^ (pos * ((m == af128_pkg::MODE_CANTOR) ? af128_pkg::MULB
                                                                   : af128_pkg::HC_LEN))
                    ^ smix(sh_tag));
    end
    f.lo = acc_lo;
    f.hi = acc_hi;
    f.cnt = pos[31:0];
    fp_due = {fp_due, f};
    acc_lo = '0; acc_hi = '0; pos = '0; held = '0;
    held_ok = 1'b0; seeded = 1'b0;
  endfunction

  // Offers one word, with a random gap in front of it, and waits for its acceptance.
  task automatic send(logic op, logic [63:0] w);
    int gap;
    gap = (!calm && $urandom_range(99) < 32) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_word(op, w);
    n_items++;
    if (op == af128_pkg::OP_END) n_ends++;
  endtask

  // Writes all three registers back to back; mode gets junk in its upper bits.
  task automatic setup(logic [1:0] m, logic [63:0] s, logic [63:0] t);
    cfg_we <= 1'b1;
    cfg_index <= af128_pkg::REG_MODE;
    cfg_wdata <= {$urandom, $urandom_range(0, 1) ? 30'h0 : 30'h3FFF_FFFF, m};
    @(posedge clk);
    cfg_index <= af128_pkg::REG_SEED;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= af128_pkg::REG_TAG;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_mode = m;
    sh_seed = s;
    sh_tag = t;
  endtask

  // Waits for every fingerprint, then lets any queued data words finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (fp_due.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [63:0] pick64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return {16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF};
      4: return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || $urandom_range(99) >= 32;
    end
  end

  // Compare each fingerprint taken from the block with the oldest one due.
  always @(posedge clk) begin
    fp_t f;
    if (rst_n && out_valid && out_ready) begin
      if (fp_due.size() == 0) begin
        $display("%0t: unexpected fingerprint %h_%h count %0d", $time,
                 out_fp_high, out_fp_low, out_word_count);
        n_err++;
      end else begin
        f = fp_due.pop_front();
        n_fp++;
        if (out_fp_low !== f.lo) begin
          $display("%0t: fp_low expected %h actual %h", $time, f.lo, out_fp_low);
          n_err++;
        end
        if (out_fp_high !== f.hi) begin
          $display("%0t: fp_high expected %h actual %h", $time, f.hi, out_fp_high);
          n_err++;
        end
        if (out_word_count !== f.cnt) begin
          $display("%0t: word_count expected %0d actual %0d", $time, f.cnt, out_word_count);
          n_err++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("timeout with %0d fingerprints outstanding", fp_due.size());
    $display("status: fail");
    $finish;
  end

  // Directed words: empty array, extreme words, odd tuple lengths.
  row_t plan[7] = '{
    '{af128_pkg::OP_END,  64'h0,                 1'b1, 32'd0},
    '{af128_pkg::OP_DATA, 64'h0,                 1'b0, 32'd0},
    '{af128_pkg::OP_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0},
    '{af128_pkg::OP_DATA, 64'h8000_0000_0000_0001, 1'b0, 32'd0},
    '{af128_pkg::OP_END,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd3},
    '{af128_pkg::OP_DATA, 64'h0123_4567_89AB_CDEF, 1'b0, 32'd0},
    '{af128_pkg::OP_END,  64'h0,                 1'b1, 32'd1}
  };

  initial begin
    int   phase, arrays, len;
    logic [63:0] s, t;
    sh_mode = af128_pkg::MODE_HASH; sh_seed = '0; sh_tag = '0;
    acc_lo = '0; acc_hi = '0; pos = '0; held = '0;
    held_ok = 1'b0; seeded = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The table is walked once per scheme, with extreme seeds and tags.
    for (int m = 0; m < 3; m++) begin
      if (m == 1) setup(af128_pkg::MODE_CANTOR, '1, '1);
      if (m == 2) setup(af128_pkg::MODE_TUPLE, '0, '1);
      foreach (plan[r]) begin
        send(plan[r].op, plan[r].word);
        if (plan[r].cnt_known && fp_due[$].cnt !== plan[r].cnt) begin
          $display("%0t: word_count expected %0d predicted %0d", $time,
                   plan[r].cnt, fp_due[$].cnt);
          n_err++;
        end
      end
      settle();
    end

    // Random phases; an array left open carries over into the next setup.
    phase = 0;
    while (n_items < 650) begin
      phase++;
      s = pick64();
      t = pick64();
      setup(2'($urandom_range(3)), s, t);
      calm = (phase % 5 == 2);
      if (phase == 4) begin
        hold_req = 1'b1;
        repeat (12) send(af128_pkg::OP_END, pick_word());
      end
      arrays = $urandom_range(1, 4);
      for (int a = 0; a < arrays; a++) begin
        len = ($urandom_range(9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 24);
        repeat (len) send(af128_pkg::OP_DATA, pick_word());
        if (a < arrays - 1 || $urandom_range(4) != 0) send(af128_pkg::OP_END, pick_word());
      end
      settle();
    end
    calm = 1'b0;
    send(af128_pkg::OP_END, '0);
    settle();

    $display("%0d words sent over %0d setups, %0d end words", n_items, phase + 2, n_ends);
    $display("%0d fingerprints checked, %0d mismatches", n_fp, n_err);
    if (n_err == 0 && fp_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/af128_pkg.sv
rtl/core/af128_front.sv
rtl/core/af128_mix.sv
rtl/core/af128_back.sv
rtl/core/array_fingerprint_128.sv
rtl/core/af128_checker.sv
tb/array_fingerprint_128_test.sv
